// ----- hdl/srgbp3_pkg.sv -----
// ----------------------------------------------------------------------------
// srgbp3_pkg
// Shared constants, types, matrices and the decode curve for the sRGB / P3
// pixel converter.
// ----------------------------------------------------------------------------
package srgbp3_pkg;

    localparam int CHANNEL_BITS     = 8;
    localparam int NUM_CODES        = 1 << CHANNEL_BITS;
    localparam int CODE_MAX         = NUM_CODES - 1;
    localparam int LINEAR_FRAC_BITS = 16;
    localparam int LANES            = 3;

    localparam int COEF_FRAC = 14;
    localparam int COEF_W    = 17;

    // decode table, two matrix stages of multiply and sum, one stage per code bit
    localparam int LATENCY   = 5 + CHANNEL_BITS;
    localparam int BUF_DEPTH = 2 ** $clog2(LATENCY + 2);
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // fixed point of the curve evaluation at elaboration
    localparam int WORK_FRAC = 30;
    localparam int KNEE      = 4045 * CODE_MAX;
    localparam int LIN_DEN   = 1292 * CODE_MAX;
    localparam int LIN_DEN2  = 2 * LIN_DEN;
    localparam int CURVE_DEN = 1055 * CODE_MAX;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic [CHANNEL_BITS-1:0]   code_t;

    typedef struct packed {
        code_t blue;
        code_t green;
        code_t red;
    } pixel_t;

    // rows and columns ordered red, green, blue; Q3.14
    localparam int SRGB_TO_XYZ [LANES][LANES] = '{
        '{6758, 5859, 2956}, '{3484, 11717, 1183}, '{317, 1953, 15570}};
    localparam int XYZ_TO_SRGB [LANES][LANES] = '{
        '{53092, -25184, -8168}, '{-15880, 30737, 681}, '{912, -3343, 17322}};
    localparam int P3_TO_XYZ [LANES][LANES] = '{
        '{7972, 4353, 3248}, '{3752, 11333, 1299}, '{0, 739, 17104}};
    localparam int XYZ_TO_P3 [LANES][LANES] = '{
        '{40853, -15260, -6598}, '{-13590, 28879, 387}, '{587, -1248, 15678}};

    // Linear light of one channel code in Q1.frac, evaluated at elaboration.
    // Above the knee: lin = v^2 * (v^2)^(1/5), fifth root by bisection.
    function automatic logic [31:0] decode_entry(input int unsigned code,
                                                 input int unsigned frac);
        logic [63:0] num;
        logic [63:0] v;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] lin;
        int          it;
        if (64'(code) * 64'd100000 <= 64'(KNEE)) begin
            num = (64'(code) * 64'd100) << (frac + 1);
            return 32'((num + 64'(LIN_DEN)) / LIN_DEN2);
        end
        v  = (64'(1000 * code + 55 * CODE_MAX) << WORK_FRAC) / CURVE_DEN;
        s  = (v * v) >> WORK_FRAC;
        lo = 64'd0;
        hi = 64'd1 << WORK_FRAC;
        for (it = 0; it < WORK_FRAC + 2; it++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                p   = (mid * mid) >> WORK_FRAC;
                p   = (p * mid) >> WORK_FRAC;
                p   = (p * mid) >> WORK_FRAC;
                p   = (p * mid) >> WORK_FRAC;
                if (p <= s) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        lin = (s * lo) >> WORK_FRAC;
        return 32'((lin + (64'd1 << (WORK_FRAC - frac - 1))) >> (WORK_FRAC - frac));
    endfunction

endpackage

// ----- hdl/srgbp3_row_lane.sv -----
// ----------------------------------------------------------------------------
// srgbp3_row_lane
// One matrix row: three products in one stage, then sum and round back to
// the linear fraction in the next.
// ----------------------------------------------------------------------------
module srgbp3_row_lane #(
    parameter int IN_W  = 18,
    parameter int OUT_W = 19
) (
    input  logic                     clk,
    input  srgbp3_pkg::coef_t        coef [srgbp3_pkg::LANES],
    input  logic signed [IN_W-1:0]   vec  [srgbp3_pkg::LANES],
    output logic signed [OUT_W-1:0]  row
);

    localparam int PROD_W = srgbp3_pkg::COEF_W + IN_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(64'd1 << (srgbp3_pkg::COEF_FRAC - 1));

    logic signed [PROD_W-1:0] prod_reg [srgbp3_pkg::LANES];
    logic signed [PROD_W-1:0] prod_next [srgbp3_pkg::LANES];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [OUT_W-1:0]  row_next;
    logic signed [OUT_W-1:0]  row_reg;

    always_comb
    begin
        for (int j = 0; j < srgbp3_pkg::LANES; j++)
        begin
            prod_next[j] = PROD_W'(coef[j]) * PROD_W'(vec[j]);
        end
    end

    always_comb
    begin
        acc      = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);
        // round to nearest, ties toward plus infinity
        acc_rnd  = acc + ROUND_HALF;
        row_next = OUT_W'(acc_rnd >>> srgbp3_pkg::COEF_FRAC);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        row_reg  <= row_next;
    end

    assign row = row_reg;

endmodule

// ----- hdl/srgbp3_encode_lane.sv -----
// ----------------------------------------------------------------------------
// srgbp3_encode_lane
// Re-encode one linear value to a channel code: clamp, then settle one code
// bit per stage against the decode table, most significant bit first.
// ----------------------------------------------------------------------------
module srgbp3_encode_lane #(
    parameter int LINEAR_FRAC_BITS = srgbp3_pkg::LINEAR_FRAC_BITS,
    parameter int RES_W            = srgbp3_pkg::LINEAR_FRAC_BITS + 5
) (
    input  logic                     clk,
    input  logic signed [RES_W-1:0]  lin,
    output srgbp3_pkg::code_t        code
);

    localparam int LIN_W = LINEAR_FRAC_BITS + 1;
    localparam int CH    = srgbp3_pkg::CHANNEL_BITS;

    logic [LIN_W-1:0]  dec_tab [srgbp3_pkg::NUM_CODES];
    logic [LIN_W-1:0]  lin_clamp;
    logic [LIN_W-1:0]  lin_reg   [CH-1];
    srgbp3_pkg::code_t code_reg  [CH];
    srgbp3_pkg::code_t code_next [CH];

    for (genvar k = 0; k < srgbp3_pkg::NUM_CODES; k++)
    begin : g_tab
        localparam logic [31:0] ENTRY = srgbp3_pkg::decode_entry(k, LINEAR_FRAC_BITS);
        assign dec_tab[k] = ENTRY[LIN_W-1:0];
    end

    // negative goes to zero, anything that overflows LIN_W bits to all ones
    always_comb
    begin
        if (lin[RES_W-1]) begin
            lin_clamp = '0;
        end else if (|lin[RES_W-2:LIN_W]) begin
            lin_clamp = '1;
        end else begin
            lin_clamp = lin[LIN_W-1:0];
        end
    end

    for (genvar s = 0; s < CH; s++)
    begin : g_step
        localparam int BIT = CH - 1 - s;
        logic [LIN_W-1:0]  lin_in;
        srgbp3_pkg::code_t code_in;
        srgbp3_pkg::code_t cand;

        if (s == 0)
        begin : g_first
            assign lin_in  = lin_clamp;
            assign code_in = '0;
        end
        else
        begin : g_rest
            assign lin_in  = lin_reg[s-1];
            assign code_in = code_reg[s-1];
        end

        // keep the bit when its threshold is at or below the value
        always_comb
        begin
            cand         = code_in | (CH'(1) << BIT);
            code_next[s] = (dec_tab[cand] <= lin_in) ? cand : code_in;
        end

        always_ff @(posedge clk)
        begin
            code_reg[s] <= code_next[s];
        end

        if (s < CH - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                lin_reg[s] <= lin_in;
            end
        end
    end

    assign code = code_reg[CH-1];

endmodule

// ----- hdl/srgbp3_merge_buf.sv -----
// ----------------------------------------------------------------------------
// srgbp3_merge_buf
// Gather the three lane codes into one pixel and queue it for the output.
// ----------------------------------------------------------------------------
module srgbp3_merge_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srgbp3_pkg::code_t   red_code,
    input  srgbp3_pkg::code_t   green_code,
    input  srgbp3_pkg::code_t   blue_code,
    input  logic                pop_stall,
    output logic                pop_valid,
    output srgbp3_pkg::pixel_t  pop_pixel
);

    localparam int AW = srgbp3_pkg::BUF_AW;

    srgbp3_pkg::pixel_t mem [srgbp3_pkg::BUF_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   cnt_reg;
    logic [AW:0]   cnt_next;
    logic          pop;

    assign pop_valid = (cnt_reg != '0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_pixel = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= '{blue: blue_code, green: green_code, red: red_code};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hdl/srgb_p3_pixel_convert_unit.sv -----
// ----------------------------------------------------------------------------
// srgb_p3_pixel_convert_unit
// BGR pixel converter between sRGB and P3 (D65 white) primaries: table decode to
// linear light, two 3x3 matrices through XYZ, table re-encode to 8-bit codes.
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------
//  in      | in_valid / in_stall      | blue_in, green_in, red_in
//  out     | out_valid / out_stall    | blue_out, green_out, red_out
//  cfg     | cfg_valid / cfg_ready    | direction (0 sRGB->P3, 1 P3->sRGB)
//
// One pixel per clock sustained while out_stall is low. An accepted beat
// passes the decode table register, the product and sum registers of both
// matrices and one register per code bit of the threshold search into the
// output queue, then out_valid. Up to 16 beats may be outstanding; in_stall
// is high while that many are. Reset clears the valid pipeline, the queue
// and direction (sRGB->P3). cfg_ready is always high.
// ----------------------------------------------------------------------------
module srgb_p3_pixel_convert_unit #(
    parameter int LINEAR_FRAC_BITS = srgbp3_pkg::LINEAR_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [srgbp3_pkg::CHANNEL_BITS-1:0] blue_in,
    input  logic [srgbp3_pkg::CHANNEL_BITS-1:0] green_in,
    input  logic [srgbp3_pkg::CHANNEL_BITS-1:0] red_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [srgbp3_pkg::CHANNEL_BITS-1:0] blue_out,
    output logic [srgbp3_pkg::CHANNEL_BITS-1:0] green_out,
    output logic [srgbp3_pkg::CHANNEL_BITS-1:0] red_out,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      direction
);

    localparam int LANES    = srgbp3_pkg::LANES;
    localparam int LATENCY  = srgbp3_pkg::LATENCY;
    localparam int LIN_W    = LINEAR_FRAC_BITS + 1;
    localparam int XYZ_IN_W = LIN_W + 1;
    localparam int XYZ_W    = LINEAR_FRAC_BITS + 3;
    localparam int RES_W    = LINEAR_FRAC_BITS + 5;
    localparam int CRED_W   = $clog2(srgbp3_pkg::BUF_DEPTH + 1);

    logic [LIN_W-1:0]          dec_tab [srgbp3_pkg::NUM_CODES];
    logic signed [XYZ_IN_W-1:0] rgb_reg  [LANES];
    logic signed [XYZ_IN_W-1:0] rgb_next [LANES];
    logic signed [XYZ_W-1:0]    xyz [LANES];
    logic signed [RES_W-1:0]    res [LANES];
    srgbp3_pkg::code_t          code [LANES];
    srgbp3_pkg::pixel_t         out_pixel;

    logic              direction_reg;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    logic [CRED_W-1:0] credit_reg;
    logic [CRED_W-1:0] credit_next;
    logic              in_accept;
    logic              out_accept;

    for (genvar k = 0; k < srgbp3_pkg::NUM_CODES; k++)
    begin : g_tab
        localparam logic [31:0] ENTRY = srgbp3_pkg::decode_entry(k, LINEAR_FRAC_BITS);
        assign dec_tab[k] = ENTRY[LIN_W-1:0];
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            direction_reg <= direction;
        end
    end

    // outstanding beats: in flight plus queued
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (credit_reg == CRED_W'(srgbp3_pkg::BUF_DEPTH));

    always_comb
    begin
        credit_next = credit_reg + CRED_W'(in_accept) - CRED_W'(out_accept);
        vld_next    = {vld_reg[LATENCY-2:0], in_accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end else begin
            credit_reg <= credit_next;
            vld_reg    <= vld_next;
        end
    end

    // decode to linear light, lanes ordered red, green, blue
    always_comb
    begin
        rgb_next[0] = XYZ_IN_W'(dec_tab[red_in]);
        rgb_next[1] = XYZ_IN_W'(dec_tab[green_in]);
        rgb_next[2] = XYZ_IN_W'(dec_tab[blue_in]);
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        srgbp3_pkg::coef_t to_xyz [LANES];
        srgbp3_pkg::coef_t to_dst [LANES];

        always_comb
        begin
            for (int j = 0; j < LANES; j++)
            begin
                to_xyz[j] = direction_reg ?
                    srgbp3_pkg::coef_t'(srgbp3_pkg::P3_TO_XYZ[i][j]) :
                    srgbp3_pkg::coef_t'(srgbp3_pkg::SRGB_TO_XYZ[i][j]);
                to_dst[j] = direction_reg ?
                    srgbp3_pkg::coef_t'(srgbp3_pkg::XYZ_TO_SRGB[i][j]) :
                    srgbp3_pkg::coef_t'(srgbp3_pkg::XYZ_TO_P3[i][j]);
            end
        end

        srgbp3_row_lane #(
            .IN_W  (XYZ_IN_W),
            .OUT_W (XYZ_W)
        ) u_to_xyz (
            .clk  (clk),
            .coef (to_xyz),
            .vec  (rgb_reg),
            .row  (xyz[i])
        );

        srgbp3_row_lane #(
            .IN_W  (XYZ_W),
            .OUT_W (RES_W)
        ) u_to_dst (
            .clk  (clk),
            .coef (to_dst),
            .vec  (xyz),
            .row  (res[i])
        );

        srgbp3_encode_lane #(
            .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
            .RES_W            (RES_W)
        ) u_encode (
            .clk  (clk),
            .lin  (res[i]),
            .code (code[i])
        );
    end

    srgbp3_merge_buf u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (vld_reg[LATENCY-1]),
        .red_code   (code[0]),
        .green_code (code[1]),
        .blue_code  (code[2]),
        .pop_stall  (out_stall),
        .pop_valid  (out_valid),
        .pop_pixel  (out_pixel)
    );

    assign blue_out  = out_pixel.blue;
    assign green_out = out_pixel.green;
    assign red_out   = out_pixel.red;

    // checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CRED_W'(srgbp3_pkg::BUF_DEPTH))
        else $error("outstanding beat count past queue depth");

    a_push_owned: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LATENCY-1] |-> credit_reg != '0)
        else $error("result pushed with no outstanding beat");

    a_out_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> credit_reg != '0)
        else $error("output valid with no outstanding beat");

    a_credit_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !out_accept |=> credit_reg == $past(credit_reg) + CRED_W'(1))
        else $error("outstanding count missed an accepted beat");

endmodule
